>>> rtl/gmlt_pkg.sv
`default_nettype none
package gmlt_pkg;

  localparam int MAX_VECTORS_DEF = 10;
  localparam int MAX_PIXELS_DEF  = 1024;

  localparam int IN_DEPTH  = 4;
  localparam int OUT_DEPTH = 8;

  localparam int VIDX_W   = 4;
  localparam int PIDX_W   = 10;
  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 32;
  localparam int DOT_W    = 48;
  localparam int KV_W     = 4;
  localparam int NP_W     = 11;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [KV_W-1:0] KV_RESET = 4'd1;
  localparam logic [NP_W-1:0] NP_RESET = 11'd1024;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic REG_KERNEL_COUNT = 1'b0;
  localparam logic REG_PIXEL_COUNT  = 1'b1;

  typedef struct packed {
    logic [KV_W-1:0] kernel_vector_count;
    logic [NP_W-1:0] pixel_count;
  } gm_cfg_t;

  typedef struct packed {
    logic              first;
    logic              last;
    logic              zero;
    logic [VIDX_W-1:0] row;
    logic [VIDX_W-1:0] column;
    logic              last_entry;
  } gm_beat_t;

  typedef struct packed {
    logic [VIDX_W-1:0]       row;
    logic [VIDX_W-1:0]       column;
    logic signed [DOT_W-1:0] dot_product;
    logic                    last_entry;
  } gm_result_t;

endpackage
`default_nettype wire

>>> rtl/gmlt_fifo.sv
`default_nettype none
module gmlt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           data_i,
  input  wire logic                       pop_i,
  output logic [WIDTH-1:0]                data_o,
  output logic                            full_o,
  output logic                            empty_o,
  output logic [$clog2(DEPTH+1)-1:0]      count_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = data_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/gmlt_front.sv
`default_nettype none
module gmlt_front #(
  parameter int MAX_VECTORS = gmlt_pkg::MAX_VECTORS_DEF,
  parameter int MAX_PIXELS  = gmlt_pkg::MAX_PIXELS_DEF,
  parameter int QW          = 1 + $clog2(MAX_VECTORS * MAX_PIXELS) + gmlt_pkg::SAMPLE_W
) (
  input  wire logic                                 push_i,
  input  wire logic                                 opcode_i,
  input  wire logic [gmlt_pkg::VIDX_W-1:0]          vector_index_i,
  input  wire logic [gmlt_pkg::PIDX_W-1:0]          pixel_index_i,
  input  wire logic signed [gmlt_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                                 q_full_i,
  output logic                                      q_push_o,
  output logic [QW-1:0]                             q_data_o
);

  localparam int AW = $clog2(MAX_VECTORS * MAX_PIXELS);

  logic          in_range;
  logic          is_cmd;
  logic [AW-1:0] addr;

  assign is_cmd   = (opcode_i == gmlt_pkg::OP_COMPUTE);
  assign in_range = (32'(vector_index_i) < MAX_VECTORS) && (32'(pixel_index_i) < MAX_PIXELS);
  assign addr     = AW'(32'(vector_index_i) * MAX_PIXELS + 32'(pixel_index_i));

  assign q_push_o = push_i && !q_full_i && (is_cmd || in_range);
  assign q_data_o = {is_cmd, addr, sample_i};

endmodule
`default_nettype wire

>>> rtl/gmlt_back.sv
`default_nettype none
module gmlt_back #(
  parameter int MAX_VECTORS = gmlt_pkg::MAX_VECTORS_DEF,
  parameter int MAX_PIXELS  = gmlt_pkg::MAX_PIXELS_DEF,
  parameter int QW          = 1 + $clog2(MAX_VECTORS * MAX_PIXELS) + gmlt_pkg::SAMPLE_W
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   q_empty_i,
  input  wire logic [QW-1:0]                          q_data_i,
  output logic                                        q_pop_o,
  input  wire gmlt_pkg::gm_cfg_t                      cfg_i,
  input  wire logic [$clog2(gmlt_pkg::OUT_DEPTH+1)-1:0] out_count_i,
  output logic                                        res_push_o,
  output gmlt_pkg::gm_result_t                        res_o
);

  localparam int AW    = $clog2(MAX_VECTORS * MAX_PIXELS);
  localparam int DEPTH = MAX_VECTORS * MAX_PIXELS;
  localparam int PW    = $clog2(MAX_PIXELS + 1);
  localparam int VW    = gmlt_pkg::VIDX_W;
  localparam int SW    = gmlt_pkg::SAMPLE_W;
  localparam int CW    = $clog2(gmlt_pkg::OUT_DEPTH + 1) + 2;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                 state_q, state_d;
  logic [VW-1:0]        r_q, r_d, c_q, c_d;
  logic [PW-1:0]        k_q, k_d;
  logic [AW-1:0]        row_base_q, row_base_d, col_base_q, col_base_d;

  logic                 q_cmd;
  logic [AW-1:0]        q_addr;
  logic signed [SW-1:0] q_sample;

  logic [VW-1:0]        kv_eff;
  logic [PW-1:0]        np_eff;
  logic                 beat_last, entry_last, credit_ok, issue, mem_we;
  logic [CW-1:0]        in_flight;
  logic [AW-1:0]        rd_addr_a, rd_addr_b;

  logic signed [SW-1:0] mem_q [DEPTH];
  logic signed [SW-1:0] rd_a_q, rd_b_q;
  logic                 valid1_q, valid2_q;
  gmlt_pkg::gm_beat_t   beat0, beat1_q, beat2_q;
  logic signed [gmlt_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [gmlt_pkg::DOT_W-1:0]  acc_d, acc_q;

  assign q_cmd    = q_data_i[QW-1];
  assign q_addr   = q_data_i[QW-2 -: AW];
  assign q_sample = q_data_i[SW-1:0];

  assign kv_eff = (32'(cfg_i.kernel_vector_count) > MAX_VECTORS - 1) ?
                  VW'(MAX_VECTORS - 1) : cfg_i.kernel_vector_count;
  assign np_eff = (32'(cfg_i.pixel_count) > MAX_PIXELS) ?
                  PW'(MAX_PIXELS) : PW'(cfg_i.pixel_count);

  assign beat_last  = ((k_q + PW'(1)) >= np_eff);
  assign entry_last = (c_q == r_q) && (r_q == kv_eff);
  assign in_flight  = CW'(valid1_q && beat1_q.last) + CW'(valid2_q && beat2_q.last);
  assign credit_ok  = (CW'(out_count_i) + in_flight) < CW'(gmlt_pkg::OUT_DEPTH);
  assign issue      = (state_q == ST_WALK) && (!beat_last || credit_ok);

  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;
  assign mem_we  = q_pop_o && !q_cmd;

  assign rd_addr_a = row_base_q + AW'(k_q);
  assign rd_addr_b = col_base_q + AW'(k_q);

  always_comb begin
    beat0.first      = (k_q == '0);
    beat0.last       = beat_last;
    beat0.zero       = (np_eff == '0);
    beat0.row        = r_q + VW'(1);
    beat0.column     = c_q + VW'(1);
    beat0.last_entry = entry_last;
  end

  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    c_d        = c_q;
    k_d        = k_q;
    row_base_d = row_base_q;
    col_base_d = col_base_q;
    case (state_q)
      ST_IDLE: begin
        if (q_pop_o && q_cmd) begin
          state_d    = ST_WALK;
          r_d        = '0;
          c_d        = '0;
          k_d        = '0;
          row_base_d = '0;
          col_base_d = '0;
        end
      end
      ST_WALK: begin
        if (issue) begin
          if (!beat_last) begin
            k_d = k_q + PW'(1);
          end else begin
            k_d = '0;
            if (c_q == r_q) begin
              if (r_q == kv_eff) begin
                state_d = ST_IDLE;
              end else begin
                r_d        = r_q + VW'(1);
                c_d        = '0;
                row_base_d = row_base_q + AW'(MAX_PIXELS);
                col_base_d = '0;
              end
            end else begin
              c_d        = c_q + VW'(1);
              col_base_d = col_base_q + AW'(MAX_PIXELS);
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid1_q <= issue;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q        <= r_d;
    c_q        <= c_d;
    k_q        <= k_d;
    row_base_q <= row_base_d;
    col_base_q <= col_base_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[q_addr] <= q_sample;
    end
    rd_a_q <= mem_q[rd_addr_a];
    rd_b_q <= mem_q[rd_addr_b];
  end

  assign prod_d = rd_a_q * rd_b_q;
  assign acc_d  = (beat2_q.first ? '0 : acc_q) + gmlt_pkg::DOT_W'(prod_q);

  always_ff @(posedge clk_i) begin
    beat1_q <= beat0;
    beat2_q <= beat1_q;
    prod_q  <= beat1_q.zero ? '0 : prod_d;
    if (valid2_q) begin
      acc_q <= acc_d;
    end
  end

  assign res_push_o = valid2_q && beat2_q.last;

  always_comb begin
    res_o.row         = beat2_q.row;
    res_o.column      = beat2_q.column;
    res_o.dot_product = acc_d;
    res_o.last_entry  = beat2_q.last_entry;
  end

endmodule
`default_nettype wire

>>> rtl/gram_matrix_lower_triangle_top.sv
// Channel   Handshake               Fields
// input     push / full             opcode_i, vector_index_i, pixel_index_i, sample_i
// result    pop / empty             row_o, column_o, dot_product_o, last_entry_o
// config    psel/penable/pwrite     paddr, pwdata, prdata, pready (always high)
//
// Sample writes are accepted one per cycle while full is low.
// A compute item walks the vector store through one dual-read memory port pair,
// one pixel per cycle unless a full result queue stalls the walk; a full matrix
// has (K+1)(K+2)/2 entries, K being the kernel vector count, each over pixel_count.
// Reset is asynchronous and active low; the vector store is not cleared.
// A full result queue stalls the walk; a busy walk fills the input queue and raises full.
`default_nettype none
module gram_matrix_lower_triangle_top #(
  parameter int MAX_VECTORS = gmlt_pkg::MAX_VECTORS_DEF,
  parameter int MAX_PIXELS  = gmlt_pkg::MAX_PIXELS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic                                 opcode_i,
  input  wire logic [gmlt_pkg::VIDX_W-1:0]          vector_index_i,
  input  wire logic [gmlt_pkg::PIDX_W-1:0]          pixel_index_i,
  input  wire logic signed [gmlt_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic [gmlt_pkg::VIDX_W-1:0]               row_o,
  output logic [gmlt_pkg::VIDX_W-1:0]               column_o,
  output logic signed [gmlt_pkg::DOT_W-1:0]         dot_product_o,
  output logic                                      last_entry_o,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [gmlt_pkg::PADDR_W-1:0]         paddr,
  input  wire logic [gmlt_pkg::PDATA_W-1:0]         pwdata,
  output logic [gmlt_pkg::PDATA_W-1:0]              prdata,
  output logic                                      pready
);

  localparam int AW = $clog2(MAX_VECTORS * MAX_PIXELS);
  localparam int QW = 1 + AW + gmlt_pkg::SAMPLE_W;
  localparam int RW = $bits(gmlt_pkg::gm_result_t);

  gmlt_pkg::gm_cfg_t    cfg_q, cfg_d;
  logic                 cfg_we;
  logic                 q_push, q_pop, q_full, q_empty;
  logic [QW-1:0]        q_wdata, q_rdata;
  logic                 res_push;
  gmlt_pkg::gm_result_t res_in, res_out;
  logic [$clog2(gmlt_pkg::OUT_DEPTH+1)-1:0] out_count;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (paddr[2])
        gmlt_pkg::REG_KERNEL_COUNT:
          cfg_d.kernel_vector_count = pwdata[gmlt_pkg::KV_W-1:0];
        gmlt_pkg::REG_PIXEL_COUNT:
          cfg_d.pixel_count = pwdata[gmlt_pkg::NP_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gmlt_pkg::REG_KERNEL_COUNT:
        prdata = gmlt_pkg::PDATA_W'(cfg_q.kernel_vector_count);
      gmlt_pkg::REG_PIXEL_COUNT:
        prdata = gmlt_pkg::PDATA_W'(cfg_q.pixel_count);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kernel_vector_count <= gmlt_pkg::KV_RESET;
      cfg_q.pixel_count         <= gmlt_pkg::NP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gmlt_front #(
    .MAX_VECTORS(MAX_VECTORS),
    .MAX_PIXELS (MAX_PIXELS),
    .QW         (QW)
  ) u_front (
    .push_i        (push),
    .opcode_i      (opcode_i),
    .vector_index_i(vector_index_i),
    .pixel_index_i (pixel_index_i),
    .sample_i      (sample_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  assign full = q_full;

  gmlt_fifo #(
    .WIDTH(QW),
    .DEPTH(gmlt_pkg::IN_DEPTH)
  ) u_in_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .full_o (q_full),
    .empty_o(q_empty),
    .count_o()
  );

  gmlt_back #(
    .MAX_VECTORS(MAX_VECTORS),
    .MAX_PIXELS (MAX_PIXELS),
    .QW         (QW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .cfg_i      (cfg_q),
    .out_count_i(out_count),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  gmlt_fifo #(
    .WIDTH(RW),
    .DEPTH(gmlt_pkg::OUT_DEPTH)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .pop_i  (pop),
    .data_o (res_out),
    .full_o (),
    .empty_o(empty),
    .count_o(out_count)
  );

  assign row_o         = res_out.row;
  assign column_o      = res_out.column;
  assign dot_product_o = res_out.dot_product;
  assign last_entry_o  = res_out.last_entry;

endmodule
`default_nettype wire

>>> rtl/gmlt_checker.sv
`default_nettype none
module gmlt_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         empty,
  input wire logic                         pop,
  input wire logic [gmlt_pkg::VIDX_W-1:0]  row_o,
  input wire logic [gmlt_pkg::VIDX_W-1:0]  column_o,
  input wire logic                         last_entry_o
);

  a_empty_out_of_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty)
    else $error("Result queue is not empty when reset is released.");

  a_lower_triangle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (column_o <= row_o) && (column_o != '0))
    else $error("Result entry lies outside the lower triangle.");

  a_last_on_diagonal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_entry_o) |-> (column_o == row_o))
    else $error("Final entry is not on the diagonal.");

  a_row_major: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_entry_o) |=> empty ||
      ((row_o == $past(row_o)) &&
       (column_o == gmlt_pkg::VIDX_W'($past(column_o) + gmlt_pkg::VIDX_W'(1)))) ||
      ((row_o == gmlt_pkg::VIDX_W'($past(row_o) + gmlt_pkg::VIDX_W'(1))) &&
       (column_o == gmlt_pkg::VIDX_W'(1))))
    else $error("Result entries are out of row-major order.");

endmodule

bind gram_matrix_lower_triangle_top gmlt_checker u_gmlt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .row_o       (row_o),
  .column_o    (column_o),
  .last_entry_o(last_entry_o)
);
`default_nettype wire
